/* src/pls_pkg.sv */
`timescale 1ns / 1ps
// Package for the path lookahead selector.
// Holds shared constants, register indexes, state types and the status struct.
package pls_pkg;

    // Number of lookahead points requested; the slot count is capped at three.
    localparam int NUM_POINTS_DEFAULT = 3;
    localparam int MAX_SLOTS          = 3;

    // Widths of the data path.
    localparam int COORD_W   = 32;
    localparam int LENGTH_W  = 32;
    localparam int SQUARE_W  = 64;
    localparam int SUM_W     = 66;
    localparam int SLOT_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Threshold register indexes; register i also serves slot i.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD  = 2'd2;

    // Threshold reset values, unsigned Q16.16 meters (1.0, 2.0 and 3.0).
    localparam logic [LENGTH_W-1:0] FIRST_RESET  = 32'h0001_0000;
    localparam logic [LENGTH_W-1:0] SECOND_RESET = 32'h0002_0000;
    localparam logic [LENGTH_W-1:0] THIRD_RESET  = 32'h0003_0000;

    localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;

    // Top level sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_ACC,
        ST_CHECK,
        ST_PAD
    } pls_state_t;

    // Segment length unit states.
    typedef enum logic [2:0] {
        D_IDLE,
        D_SQ,
        D_ADD,
        D_LOAD,
        D_ROOT
    } pls_dist_state_t;

    // Status handed from the segment length unit to the sequencer.
    typedef struct packed {
        logic done;
        logic over;
    } pls_dist_stat_t;

endpackage

/* src/pls_isqrt.sv */
`timescale 1ns / 1ps
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on pls_pkg for widths.
module pls_isqrt
    import pls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQUARE_W-1:0] value,
    output logic                done,
    output logic [LENGTH_W-1:0] root
);

    logic [SQUARE_W-1:0] val_reg;
    logic [SQUARE_W-1:0] val_next;
    logic [32:0]         rem_reg;
    logic [32:0]         rem_next;
    logic [LENGTH_W-1:0] root_reg;
    logic [LENGTH_W-1:0] root_next;
    logic [4:0]          cnt_reg;
    logic [4:0]          cnt_next;
    logic                run_reg;
    logic                run_next;
    logic                done_reg;
    logic                done_next;
    logic [34:0]         rem_sh;
    logic [34:0]         trial;
    logic [34:0]         diff;

    // One restoring step: bring down two bits, try to subtract 4*root+1.
    always_comb
    begin
        rem_sh    = {rem_reg, val_reg[SQUARE_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            val_next = {val_reg[SQUARE_W-3:0], 2'b00};
            cnt_next = cnt_reg + 5'd1;
            if (rem_sh >= trial)
            begin
                rem_next  = diff[32:0];
                root_next = {root_reg[LENGTH_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[32:0];
                root_next = {root_reg[LENGTH_W-2:0], 1'b0};
            end
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* src/pls_dist.sv */
`timescale 1ns / 1ps
// Segment length unit: one shared squarer sums the three squared deltas,
// then the iterative square root gives the floor of the length. Uses pls_pkg, pls_isqrt.
module pls_dist
    import pls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [COORD_W-1:0]   cur_x,
    input  logic [COORD_W-1:0]   cur_y,
    input  logic [COORD_W-1:0]   cur_z,
    input  logic [COORD_W-1:0]   prev_x,
    input  logic [COORD_W-1:0]   prev_y,
    input  logic [COORD_W-1:0]   prev_z,
    output pls_dist_stat_t       stat,
    output logic [LENGTH_W-1:0]  root
);

    pls_dist_state_t     state_reg;
    pls_dist_state_t     state_next;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic [SQUARE_W-1:0] sq_reg;
    logic [SQUARE_W-1:0] sq_next;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;
    logic [COORD_W-1:0]  a_sel;
    logic [COORD_W-1:0]  b_sel;
    logic [COORD_W:0]    delta;
    logic [COORD_W-1:0]  mag;
    logic                sqrt_start;
    logic                sqrt_done;

    // Pick the axis for this pass and take the magnitude of its delta.
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                a_sel = cur_x;
                b_sel = prev_x;
            end
            2'd1:
            begin
                a_sel = cur_y;
                b_sel = prev_y;
            end
            default:
            begin
                a_sel = cur_z;
                b_sel = prev_z;
            end
        endcase
        delta = {a_sel[COORD_W-1], a_sel} - {b_sel[COORD_W-1], b_sel};
        mag   = delta[COORD_W] ? COORD_W'(-delta) : delta[COORD_W-1:0];
    end

    // Sequencer: three squaring passes, a final add, then the root.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        sqrt_start = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    sq_next    = '0;
                    acc_next   = '0;
                    state_next = D_SQ;
                end
            end
            D_SQ:
            begin
                sq_next  = mag * mag;
                acc_next = acc_reg + {2'b00, sq_reg};
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = D_ADD;
                end
            end
            D_ADD:
            begin
                acc_next   = acc_reg + {2'b00, sq_reg};
                state_next = D_LOAD;
            end
            D_LOAD:
            begin
                sqrt_start = 1'b1;
                state_next = D_ROOT;
            end
            D_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
    end

    pls_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (acc_reg[SQUARE_W-1:0]),
        .done  (sqrt_done),
        .root  (root)
    );

    // A squared length of 2^64 or more saturates the running length.
    assign stat.done = sqrt_done;
    assign stat.over = (acc_reg[SUM_W-1:SQUARE_W] != 2'b00);

endmodule

/* src/path_lookahead_selector.sv */
`timescale 1ns / 1ps
// Path lookahead selector top level. The first pose of a path needs no length pass; unless it
// is final, the input is free again on the next cycle. A final first pose pads each open slot
// and then clears the path. A later pose holds the input through three squaring passes, an add,
// a root load, 32 square root steps, the accumulate and the closing threshold check, then through
// each emitted or padded word and, on a final pose, the clearing step; stalls on the output add
// to this. One pose is in work at a time. Reset restores the default thresholds and clears the
// path state; no clearing pass is needed.
module path_lookahead_selector
    import pls_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [COORD_W-1:0]   pos_x,
    input  logic [COORD_W-1:0]   pos_y,
    input  logic [COORD_W-1:0]   pos_z,
    input  logic                 final_pose,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COORD_W-1:0]   point_x,
    output logic [COORD_W-1:0]   point_y,
    output logic [COORD_W-1:0]   point_z,
    output logic [SLOT_W-1:0]    slot_index,
    output logic                 last_point,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LENGTH_W-1:0]  cfg_data
);

    localparam int SLOTS = (NUM_POINTS < MAX_SLOTS) ? NUM_POINTS : MAX_SLOTS;
    localparam logic [SLOT_W-1:0] SLOTS_C = SLOT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    pls_state_t           state_reg;
    pls_state_t           state_next;
    logic [LENGTH_W-1:0]  first_reg, first_next;
    logic [LENGTH_W-1:0]  second_reg, second_next;
    logic [LENGTH_W-1:0]  third_reg, third_next;
    logic                 have_prev_reg, have_prev_next;
    logic [LENGTH_W-1:0]  length_reg, length_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 fin_reg, fin_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   cur_x_reg, cur_y_reg, cur_z_reg;
    logic [COORD_W-1:0]   cur_x_next, cur_y_next, cur_z_next;
    logic [COORD_W-1:0]   prev_x_reg, prev_y_reg, prev_z_reg;
    logic [COORD_W-1:0]   prev_x_next, prev_y_next, prev_z_next;
    logic [COORD_W-1:0]   emit_x_reg, emit_y_reg, emit_z_reg;
    logic [COORD_W-1:0]   emit_x_next, emit_y_next, emit_z_next;
    logic [COORD_W-1:0]   px_reg, py_reg, pz_reg;
    logic [COORD_W-1:0]   px_next, py_next, pz_next;
    logic [SLOT_W-1:0]    pslot_reg, pslot_next;
    logic                 plast_reg, plast_next;
    logic                 dist_start;
    pls_dist_stat_t       dist_stat;
    logic [LENGTH_W-1:0]  seg_len;
    logic [LENGTH_W:0]    len_sum;
    logic [LENGTH_W-1:0]  thr_sel;
    logic                 out_free;
    logic                 slot_open;
    logic [COORD_W-1:0]   pad_x, pad_y, pad_z;

    // Segment length unit with the shared squarer and square root.
    pls_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dist_start),
        .cur_x  (cur_x_reg),
        .cur_y  (cur_y_reg),
        .cur_z  (cur_z_reg),
        .prev_x (prev_x_reg),
        .prev_y (prev_y_reg),
        .prev_z (prev_z_reg),
        .stat   (dist_stat),
        .root   (seg_len)
    );

    // Threshold of the next slot to fill.
    always_comb
    begin
        case (slot_reg)
            CFG_FIRST:  thr_sel = first_reg;
            CFG_SECOND: thr_sel = second_reg;
            default:    thr_sel = third_reg;
        endcase
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign slot_open = (slot_reg < SLOTS_C);
    assign len_sum   = {1'b0, length_reg} + {1'b0, seg_len};

    // Padding uses the last emitted point once any slot is filled.
    assign pad_x = (slot_reg != '0) ? emit_x_reg : cur_x_reg;
    assign pad_y = (slot_reg != '0) ? emit_y_reg : cur_y_reg;
    assign pad_z = (slot_reg != '0) ? emit_z_reg : cur_z_reg;

    // Sequencer, configuration writes and output register.
    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        have_prev_next = have_prev_reg;
        length_next    = length_reg;
        slot_next      = slot_reg;
        fin_next       = fin_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_z_next     = cur_z_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_z_next    = prev_z_reg;
        emit_x_next    = emit_x_reg;
        emit_y_next    = emit_y_reg;
        emit_z_next    = emit_z_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        pslot_next     = pslot_reg;
        plast_next     = plast_reg;
        out_valid_next = out_valid_reg && out_stall;
        dist_start     = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST:  first_next  = cfg_data;
                CFG_SECOND: second_next = cfg_data;
                CFG_THIRD:  third_next  = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_x_next = pos_x;
                    cur_y_next = pos_y;
                    cur_z_next = pos_z;
                    fin_next   = final_pose;
                    if (have_prev_reg)
                    begin
                        dist_start = 1'b1;
                        state_next = ST_DIST;
                    end
                    else
                    begin
                        // First pose of a path has no segment to measure.
                        prev_x_next    = pos_x;
                        prev_y_next    = pos_y;
                        prev_z_next    = pos_z;
                        have_prev_next = 1'b1;
                        state_next     = final_pose ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_DIST:
            begin
                if (dist_stat.done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // Saturating accumulation of the running path length.
                if (dist_stat.over || len_sum[LENGTH_W])
                begin
                    length_next = LENGTH_MAX;
                end
                else
                begin
                    length_next = len_sum[LENGTH_W-1:0];
                end
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                prev_z_next = cur_z_reg;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (slot_open && (length_reg >= thr_sel))
                begin
                    if (out_free)
                    begin
                        px_next        = cur_x_reg;
                        py_next        = cur_y_reg;
                        pz_next        = cur_z_reg;
                        pslot_next     = slot_reg;
                        plast_next     = (slot_reg == LAST_SLOT);
                        out_valid_next = 1'b1;
                        emit_x_next    = cur_x_reg;
                        emit_y_next    = cur_y_reg;
                        emit_z_next    = cur_z_reg;
                        slot_next      = slot_reg + 2'd1;
                    end
                end
                else
                begin
                    state_next = fin_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (slot_open)
                begin
                    if (out_free)
                    begin
                        px_next        = pad_x;
                        py_next        = pad_y;
                        pz_next        = pad_z;
                        pslot_next     = slot_reg;
                        plast_next     = (slot_reg == LAST_SLOT);
                        out_valid_next = 1'b1;
                        emit_x_next    = pad_x;
                        emit_y_next    = pad_y;
                        emit_z_next    = pad_z;
                        slot_next      = slot_reg + 2'd1;
                    end
                end
                else
                begin
                    // Path done: clear for the next one.
                    have_prev_next = 1'b0;
                    length_next    = '0;
                    slot_next      = '0;
                    fin_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= FIRST_RESET;
            second_reg    <= SECOND_RESET;
            third_reg     <= THIRD_RESET;
            have_prev_reg <= 1'b0;
            length_reg    <= '0;
            slot_reg      <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            third_reg     <= third_next;
            have_prev_reg <= have_prev_next;
            length_reg    <= length_next;
            slot_reg      <= slot_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pose and output word registers.
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        cur_z_reg  <= cur_z_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        prev_z_reg <= prev_z_next;
        emit_x_reg <= emit_x_next;
        emit_y_reg <= emit_y_next;
        emit_z_reg <= emit_z_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pz_reg     <= pz_next;
        pslot_reg  <= pslot_next;
        plast_reg  <= plast_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign point_z    = pz_reg;
    assign slot_index = pslot_reg;
    assign last_point = plast_reg;

    // The slot counter never passes the slot count.
    assert property (@(posedge clk) disable iff (!rst_n) slot_reg <= SLOTS_C)
        else $error("slot counter beyond slot count");

    // Without a previous pose no slot can have been filled.
    assert property (@(posedge clk) disable iff (!rst_n) !have_prev_reg |-> slot_reg == '0)
        else $error("slot filled without a previous pose");

    // The length unit only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n) dist_stat.done |-> state_reg == ST_DIST)
        else $error("segment length finished outside its wait state");

    // A new output word is only loaded when the old one was taken or absent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(pslot_reg)))
        else $error("pending output word overwritten");

endmodule

/* dv/path_lookahead_selector_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for path_lookahead_selector: paths of poses go in, lookahead words come out.
// A local predictor of the slot selection checks every word. Depends only on pls_pkg and the RTL.
module path_lookahead_selector_tb;
    import pls_pkg::*;

    typedef logic [COORD_W-1:0] coord_t;

    // One expected lookahead word.
    typedef struct packed {
        coord_t              x;
        coord_t              y;
        coord_t              z;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } lookahead_point_t;

    localparam int SLOT_COUNT = (NUM_POINTS_DEFAULT < MAX_SLOTS) ? NUM_POINTS_DEFAULT : MAX_SLOTS;
    localparam coord_t ONE_M  = 32'h0001_0000;
    localparam coord_t MIN_C  = 32'h8000_0000;
    localparam coord_t MAX_C  = 32'h7FFF_FFFF;
    // Settling wait, long enough for a busy pose that emits nothing to finish.
    localparam int SETTLE_CYCLES = 80;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               pos_z;
    logic                 final_pose;
    logic                 out_valid;
    logic                 out_stall;
    coord_t               point_x;
    coord_t               point_y;
    coord_t               point_z;
    logic [SLOT_W-1:0]    slot_index;
    logic                 last_point;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LENGTH_W-1:0]  cfg_data;

    // Predictor state: thresholds and the path in progress.
    logic [LENGTH_W-1:0]  slot_threshold [3];
    coord_t               trail_prev [3];
    bit                   trail_started;
    logic [LENGTH_W-1:0]  trail_length;
    int                   trail_slot;
    coord_t               trail_emitted [3];

    lookahead_point_t     pending_points [$];

    int  error_count;
    int  poses_sent;
    int  words_checked;
    int  cfg_writes;
    bit  steady;

    path_lookahead_selector i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .final_pose (final_pose),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .slot_index (slot_index),
        .last_point (last_point),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit, far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d words still expected.", pending_points.size());
        $display("** path_lookahead_selector: FAILED **");
        $finish;
    end

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Floor of the square root of a 64-bit value, one result bit per pass.
    function automatic logic [31:0] floor_root(logic [63:0] value);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] probe;
        rest  = value;
        root  = '0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rest)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[31:0];
    endfunction

    function automatic void push_point(coord_t p [3], int slot);
        lookahead_point_t w;
        w.x    = p[0];
        w.y    = p[1];
        w.z    = p[2];
        w.slot = slot[SLOT_W-1:0];
        w.last = (slot + 1 == SLOT_COUNT);
        pending_points.insert(pending_points.size(), w);
    endfunction

    function automatic void clear_trail();
        for (int i = 0; i < 3; i++)
        begin
            trail_prev[i]    = '0;
            trail_emitted[i] = '0;
        end
        trail_started = 1'b0;
        trail_length  = '0;
        trail_slot    = 0;
    endfunction

    // Works out the words that one accepted pose causes.
    function automatic void predict_pose(coord_t x, coord_t y, coord_t z, logic fin);
        coord_t            cur [3];
        coord_t            pad [3];
        logic [SUM_W-1:0]  sq_sum;
        logic signed [32:0] delta;
        logic [31:0]       mag;
        logic [63:0]       sq;
        logic [32:0]       total;
        cur[0] = x;
        cur[1] = y;
        cur[2] = z;
        if (trail_started)
        begin
            sq_sum = '0;
            for (int i = 0; i < 3; i++)
            begin
                delta  = $signed({cur[i][31], cur[i]}) - $signed({trail_prev[i][31], trail_prev[i]});
                mag    = delta[32] ? 32'(-delta) : delta[31:0];
                sq     = 64'(mag) * 64'(mag);
                sq_sum = sq_sum + SUM_W'(sq);
            end
            // A squared length of 2^64 or more pins the running length.
            if (sq_sum[SUM_W-1:64] != 0)
            begin
                trail_length = LENGTH_MAX;
            end
            else
            begin
                total        = {1'b0, trail_length} + {1'b0, floor_root(sq_sum[63:0])};
                trail_length = total[32] ? LENGTH_MAX : total[31:0];
            end
            while (trail_slot < SLOT_COUNT && trail_length >= slot_threshold[trail_slot])
            begin
                push_point(cur, trail_slot);
                trail_emitted = cur;
                trail_slot++;
            end
        end
        trail_prev    = cur;
        trail_started = 1'b1;
        if (fin)
        begin
            if (trail_slot > 0)
            begin
                pad = trail_emitted;
            end
            else
            begin
                pad = cur;
            end
            while (trail_slot < SLOT_COUNT)
            begin
                push_point(pad, trail_slot);
                trail_slot++;
            end
            clear_trail();
        end
    endfunction

    // Output side: stall at random unless the run is in its steady stretch.
    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 15);
    end

    // Each word shown with stall low is taken at the next rising edge.
    always @(negedge clk)
    begin
        lookahead_point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_points.size() == 0)
            begin
                report_error($sformatf("unexpected word x=%h y=%h z=%h slot=%0d last=%b",
                                       point_x, point_y, point_z, slot_index, last_point));
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x || point_y !== want.y || point_z !== want.z ||
                    slot_index !== want.slot || last_point !== want.last)
                begin
                    report_error($sformatf({"word mismatch: expected x=%h y=%h z=%h slot=%0d ",
                                            "last=%b, got x=%h y=%h z=%h slot=%0d last=%b"},
                                           want.x, want.y, want.z, want.slot, want.last,
                                           point_x, point_y, point_z, slot_index, last_point));
                end
            end
        end
    end

    // Sends one pose; returns at the edge where it was taken.
    task automatic send_pose(coord_t x, coord_t y, coord_t z, logic fin);
        bit taken;
        if (!steady)
        begin
            while ($urandom_range(99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        final_pose <= fin;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        predict_pose(x, y, z, fin);
        poses_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LENGTH_W-1:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        slot_threshold[idx] = value;
        cfg_writes++;
    endtask

    task automatic write_thresholds(logic [LENGTH_W-1:0] t0, logic [LENGTH_W-1:0] t1,
                                    logic [LENGTH_W-1:0] t2);
        write_reg(CFG_FIRST, t0);
        write_reg(CFG_SECOND, t1);
        write_reg(CFG_THIRD, t2);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every expected word is in, then lets a busy pose finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic coord_t nudge(coord_t base, int span);
        int off;
        off = int'($urandom_range(0, 2 * span)) - span;
        return base + coord_t'(off);
    endfunction

    // Reset thresholds: exact hits, partial fill, padding and single poses at the extremes.
    task automatic test_default_thresholds();
        send_pose(MIN_C, MIN_C, MIN_C, 1'b1);
        send_pose(MAX_C, MAX_C, MAX_C, 1'b1);
        send_pose('0, '0, '0, 1'b0);
        send_pose(ONE_M, '0, '0, 1'b0);
        send_pose(ONE_M, ONE_M, '0, 1'b0);
        send_pose(ONE_M, ONE_M, ONE_M >> 1, 1'b1);
        send_pose(-(3 * ONE_M), -(4 * ONE_M), '0, 1'b0);
        send_pose(-(3 * ONE_M), -(4 * ONE_M) + (ONE_M >> 1), '0, 1'b1);
        // One step fills every slot, later poses add length only.
        send_pose('0, '0, '0, 1'b0);
        send_pose(3 * ONE_M, 4 * ONE_M, '0, 1'b0);
        send_pose(6 * ONE_M, 8 * ONE_M, '0, 1'b0);
        send_pose(6 * ONE_M, 8 * ONE_M, ONE_M, 1'b1);
        settle();
    endtask

    // Zero thresholds are met by the second pose, all slots at once.
    task automatic test_zero_thresholds();
        write_thresholds('0, '0, '0);
        send_pose(32'h0005_0000, 32'hFFFB_0000, 32'h0005_8000, 1'b0);
        send_pose(32'h0005_0000, 32'hFFFB_0000, 32'h0005_8000, 1'b0);
        send_pose(32'h0006_0000, 32'hFFFB_0000, 32'h0005_8000, 1'b1);
        send_pose(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_F0F0, 1'b1);
        settle();
    endtask

    // Top thresholds are reached by saturation, from overflow or from the sum, or by one full-range axis step.
    task automatic test_saturation();
        write_thresholds(LENGTH_MAX, LENGTH_MAX, LENGTH_MAX);
        send_pose(MIN_C, MIN_C, MIN_C, 1'b0);
        send_pose(MAX_C, MAX_C, MAX_C, 1'b1);
        send_pose(MIN_C, '0, '0, 1'b0);
        send_pose(MAX_C, '0, '0, 1'b1);
        send_pose('0, '0, '0, 1'b0);
        send_pose(MAX_C, '0, '0, 1'b0);
        send_pose('0, '0, '0, 1'b0);
        send_pose('0, MAX_C, '0, 1'b1);
        settle();
    endtask

    // Well-formed paths with random steps; a few poses jump anywhere.
    task automatic run_paths(int n_items, int span);
        int     sent;
        int     hops;
        coord_t px;
        coord_t py;
        coord_t pz;
        sent = 0;
        while (sent < n_items)
        begin
            hops = $urandom_range(1, 10);
            if ($urandom_range(9) == 0)
            begin
                px = $urandom;
                py = $urandom;
                pz = $urandom;
            end
            else
            begin
                px = nudge('0, 1 << 20);
                py = nudge('0, 1 << 20);
                pz = nudge('0, 1 << 20);
            end
            for (int k = 0; k < hops; k++)
            begin
                if (k > 0)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        px = $urandom;
                        py = $urandom;
                        pz = $urandom;
                    end
                    else
                    begin
                        px = nudge(px, span);
                        py = nudge(py, span);
                        pz = nudge(pz, span);
                    end
                end
                send_pose(px, py, pz, k == hops - 1);
                sent++;
            end
        end
        settle();
    endtask

    task automatic test_random_paths();
        write_thresholds(FIRST_RESET, SECOND_RESET, THIRD_RESET);
        run_paths(70, 1 << 16);
        // Steady stretch: neither side idles.
        steady = 1'b1;
        write_thresholds($urandom_range(0, 4 << 16), $urandom_range(0, 4 << 16),
                         $urandom_range(0, 4 << 16));
        run_paths(70, 1 << 16);
        steady = 1'b0;
        write_thresholds(ONE_M >> 2, ONE_M >> 1, (3 * ONE_M) >> 2);
        run_paths(60, 1 << 14);
        // Thresholds out of order fill several slots together.
        write_thresholds(3 * ONE_M, ONE_M, '0);
        run_paths(60, 1 << 16);
        write_thresholds($urandom, $urandom, $urandom);
        run_paths(60, 1 << 29);
    endtask

    initial
    begin
        error_count   = 0;
        poses_sent    = 0;
        words_checked = 0;
        cfg_writes    = 0;
        steady        = 1'b0;
        slot_threshold[0] = FIRST_RESET;
        slot_threshold[1] = SECOND_RESET;
        slot_threshold[2] = THIRD_RESET;
        clear_trail();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        pos_x      <= '0;
        pos_y      <= '0;
        pos_z      <= '0;
        final_pose <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_FIRST;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_thresholds();
        test_zero_thresholds();
        test_saturation();
        test_random_paths();

        // Final drain with a bound; anything left over is a failure.
        in_valid <= 1'b0;
        for (int i = 0; i < 5000 && pending_points.size() != 0; i++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_points.size() != 0)
        begin
            report_error($sformatf("%0d expected words never arrived", pending_points.size()));
        end

        $display("Sent %0d poses over reset, zero, saturating and random thresholds.", poses_sent);
        $display("Checked %0d lookahead words after %0d register writes; %0d errors.",
                 words_checked, cfg_writes, error_count);
        if (error_count == 0)
        begin
            $display("** path_lookahead_selector: PASSED **");
        end
        else
        begin
            $display("** path_lookahead_selector: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
src/pls_pkg.sv
src/pls_isqrt.sv
src/pls_dist.sv
src/path_lookahead_selector.sv
dv/path_lookahead_selector_tb.sv
